### hdl/zpd_pkg.sv
// Shared types and constants for the z-score presence debouncer.
// No dependencies; imported by zpd_eval and zscore_presence_debouncer.
package zpd_pkg;

	localparam int unsigned ENERGY_W = 16;
	localparam int unsigned DIST_W   = 10;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned HOLD_W   = 24;
	localparam int unsigned MULT_W   = 14;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned S_TDATA_W  = 64;
	localparam int unsigned M_TDATA_W  = 8;

	// lower edge of the accepted distance window
	localparam logic [DIST_W-1:0] NEAR_LIMIT_CM = 10'd0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_LEVEL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ON_MULTIPLIER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_MULTIPLIER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ON_HOLD_MS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_HOLD_MS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_DELAY_MS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT_CM   = 3'd7;

	// reset values of the configuration registers
	localparam logic [ENERGY_W-1:0]      RST_MEAN_LEVEL     = 16'd1715;
	localparam logic [ENERGY_W-1:0]      RST_SPREAD         = 16'd896;
	localparam logic signed [MULT_W-1:0] RST_ON_MULTIPLIER  = 14'sd2304;
	localparam logic signed [MULT_W-1:0] RST_OFF_MULTIPLIER = 14'sd1024;
	localparam logic [HOLD_W-1:0]        RST_ON_HOLD_MS     = 24'd3000;
	localparam logic [HOLD_W-1:0]        RST_OFF_HOLD_MS    = 24'd5000;
	localparam logic [HOLD_W-1:0]        RST_CLEAR_DELAY_MS = 24'd30000;
	localparam logic [DIST_W-1:0]        RST_FAR_LIMIT_CM   = 10'd600;

	// change event codes
	localparam logic [1:0] EVT_NONE   = 2'd0;
	localparam logic [1:0] EVT_ROSE   = 2'd1;
	localparam logic [1:0] EVT_FELL   = 2'd2;

	// threshold test results for one frame
	typedef struct packed {
		logic high;    // z >= k_on
		logic exceed;  // z >  k_on
		logic low;     // z <  k_off
	} zpd_cmp_t;

endpackage

### hdl/zscore_presence_debouncer.sv
// Top level of the z-score presence debouncer: stream ports, config registers,
// debounce state machine and result register. Depends on zpd_pkg and zpd_eval.
//
// Each radar frame beat on the slave side yields exactly one result beat on the
// master side. A frame is registered on entry, evaluated in one pass through two
// 14x17 multiply-compare paths and the state update, and lands in the result
// register; one frame is taken every cycle while
// m_tready stays high. While a finished result waits for m_tready, one more frame
// is taken into the input register and then s_tready drops until the result
// drains. Frames whose valid distance lies outside
// [NEAR_LIMIT_CM, far_limit_cm] leave the state alone and report frame_used = 0.
// Timestamps wrap at 32 bits. Configuration is written through cfg_* (always
// ready) and must only change while no frame is in flight.
module zscore_presence_debouncer import zpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// frames
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // energy[15:0], distance_cm[25:16],
	                                         // now_ms[57:26], zero[63:58]
	input  logic                  s_tuser,   // distance_valid
	// results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // present[0], phase[2:1],
	                                         // change_event[4:3], frame_used[5], zero[7:6]
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ON_DEB  = 2'd1,
		PH_PRESENT = 2'd2,
		PH_OFF_DEB = 2'd3
	} phase_t;

	// configuration registers
	logic [ENERGY_W-1:0]      mean_level_q;
	logic [ENERGY_W-1:0]      spread_q;
	logic signed [MULT_W-1:0] on_mult_q;
	logic signed [MULT_W-1:0] off_mult_q;
	logic [HOLD_W-1:0]        on_hold_q;
	logic [HOLD_W-1:0]        off_hold_q;
	logic [HOLD_W-1:0]        clear_delay_q;
	logic [DIST_W-1:0]        far_limit_q;

	// input stage
	logic                     vld_s1;
	logic [ENERGY_W-1:0]      energy_s1;
	logic [DIST_W-1:0]        dist_s1;
	logic                     dvalid_s1;
	logic [TIME_W-1:0]        now_s1;

	// debounce state
	phase_t                   phase_q;
	logic [TIME_W-1:0]        hold_start_q;
	logic [TIME_W-1:0]        last_strong_q;

	// result register
	logic                     out_vld_q;
	logic                     present_q;
	phase_t                   out_phase_q;
	logic [1:0]               event_q;
	logic                     used_q;

	logic                     adv;
	logic                     used;
	zpd_cmp_t                 cmp;
	phase_t                   phase_nxt;
	logic [TIME_W-1:0]        hold_start_nxt;
	logic [TIME_W-1:0]        last_strong_nxt;
	logic [1:0]               event_nxt;
	logic [TIME_W-1:0]        since_hold;
	logic [TIME_W-1:0]        since_strong;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_level_q  <= RST_MEAN_LEVEL;
			spread_q      <= RST_SPREAD;
			on_mult_q     <= RST_ON_MULTIPLIER;
			off_mult_q    <= RST_OFF_MULTIPLIER;
			on_hold_q     <= RST_ON_HOLD_MS;
			off_hold_q    <= RST_OFF_HOLD_MS;
			clear_delay_q <= RST_CLEAR_DELAY_MS;
			far_limit_q   <= RST_FAR_LIMIT_CM;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MEAN_LEVEL:     mean_level_q  <= cfg_data[ENERGY_W-1:0];
				REG_SPREAD:         spread_q      <= cfg_data[ENERGY_W-1:0];
				REG_ON_MULTIPLIER:  on_mult_q     <= $signed(cfg_data[MULT_W-1:0]);
				REG_OFF_MULTIPLIER: off_mult_q    <= $signed(cfg_data[MULT_W-1:0]);
				REG_ON_HOLD_MS:     on_hold_q     <= cfg_data[HOLD_W-1:0];
				REG_OFF_HOLD_MS:    off_hold_q    <= cfg_data[HOLD_W-1:0];
				REG_CLEAR_DELAY_MS: clear_delay_q <= cfg_data[HOLD_W-1:0];
				REG_FAR_LIMIT_CM:   far_limit_q   <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// s1 moves into the result register whenever that register is free or drains
	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			energy_s1 <= s_tdata[15:0];
			dist_s1   <= s_tdata[25:16];
			now_s1    <= s_tdata[57:26];
			dvalid_s1 <= s_tuser;
		end
	end

	zpd_eval u_eval (
		.energy         (energy_s1),
		.mean_level     (mean_level_q),
		.spread         (spread_q),
		.on_multiplier  (on_mult_q),
		.off_multiplier (off_mult_q),
		.cmp            (cmp)
	);

	assign used = !(dvalid_s1 && ((dist_s1 < NEAR_LIMIT_CM) || (dist_s1 > far_limit_q)));
	assign since_hold   = now_s1 - hold_start_q;
	assign since_strong = now_s1 - last_strong_q;

	always_comb begin
		phase_nxt       = phase_q;
		hold_start_nxt  = hold_start_q;
		last_strong_nxt = last_strong_q;
		event_nxt       = EVT_NONE;
		if (used) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (cmp.high) begin
						hold_start_nxt = now_s1;
						phase_nxt      = PH_ON_DEB;
					end
				end
				PH_ON_DEB: begin
					if (!cmp.high) begin
						phase_nxt = PH_IDLE;
					end else if (since_hold >= {8'b0, on_hold_q}) begin
						phase_nxt       = PH_PRESENT;
						last_strong_nxt = now_s1;
						event_nxt       = EVT_ROSE;
					end
				end
				PH_PRESENT: begin
					// strong refresh counts before the clear-delay test
					if (cmp.exceed) begin
						last_strong_nxt = now_s1;
					end
					if (cmp.low && (cmp.exceed ? (clear_delay_q == '0)
						: (since_strong >= {8'b0, clear_delay_q}))) begin
						hold_start_nxt = now_s1;
						phase_nxt      = PH_OFF_DEB;
					end
				end
				PH_OFF_DEB: begin
					priority if (cmp.low) begin
						if (since_hold >= {8'b0, off_hold_q}) begin
							phase_nxt = PH_IDLE;
							event_nxt = EVT_FELL;
						end
					end else if (cmp.high) begin
						phase_nxt       = PH_PRESENT;
						last_strong_nxt = now_s1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			hold_start_q  <= '0;
			last_strong_q <= '0;
			out_vld_q     <= 1'b0;
		end else begin
			if (adv) begin
				phase_q       <= phase_nxt;
				hold_start_q  <= hold_start_nxt;
				last_strong_q <= last_strong_nxt;
				out_vld_q     <= 1'b1;
			end else if (m_tready) begin
				out_vld_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			present_q   <= phase_nxt[1];
			out_phase_q <= phase_nxt;
			event_q     <= event_nxt;
			used_q      <= used;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, used_q, event_q, out_phase_q, present_q};

	// a rise is only ever reported together with the present phase
	a_rose_present: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && event_q == EVT_ROSE) |-> (out_phase_q == PH_PRESENT))
		else $error("rise event without present phase");

	a_fell_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && event_q == EVT_FELL) |-> (out_phase_q == PH_IDLE))
		else $error("fall event without idle phase");

	a_unused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !used_q) |-> (event_q == EVT_NONE))
		else $error("event on a rejected frame");

	a_unused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !used) |=> (phase_q == $past(phase_q) && hold_start_q == $past(hold_start_q)))
		else $error("rejected frame changed the state");

endmodule

### hdl/zpd_eval.sv
// Threshold tests of one frame: z-score against on and off levels, no divide.
// Depends on zpd_pkg.
module zpd_eval import zpd_pkg::*; (
	input  logic [ENERGY_W-1:0]      energy,
	input  logic [ENERGY_W-1:0]      mean_level,
	input  logic [ENERGY_W-1:0]      spread,
	input  logic signed [MULT_W-1:0] on_multiplier,
	input  logic signed [MULT_W-1:0] off_multiplier,
	output zpd_cmp_t                 cmp
);

	localparam int unsigned PROD_W = MULT_W + ENERGY_W + 1;

	logic signed [ENERGY_W:0]     diff;
	logic signed [ENERGY_W+8:0]   num;
	logic signed [ENERGY_W:0]     spread_s;
	logic signed [PROD_W-1:0]     on_prod;
	logic signed [PROD_W-1:0]     off_prod;
	logic signed [PROD_W-1:0]     lhs;
	logic signed [PROD_W-1:0]     on_rhs;
	logic signed [PROD_W-1:0]     off_rhs;
	logic                         spread_zero;

	assign diff     = $signed({1'b0, energy}) - $signed({1'b0, mean_level});
	assign num      = {diff, 8'b0};
	assign spread_s = $signed({1'b0, spread});
	assign on_prod  = PROD_W'(on_multiplier) * PROD_W'(spread_s);
	assign off_prod = PROD_W'(off_multiplier) * PROD_W'(spread_s);

	// zero spread: z is taken as 0, so compare 0 against k directly
	assign spread_zero = (spread == '0);
	assign lhs     = spread_zero ? '0 : PROD_W'(num);
	assign on_rhs  = spread_zero ? PROD_W'(on_multiplier) : on_prod;
	assign off_rhs = spread_zero ? PROD_W'(off_multiplier) : off_prod;

	assign cmp.high   = (lhs >= on_rhs);
	assign cmp.exceed = (lhs > on_rhs);
	assign cmp.low    = (lhs < off_rhs);

endmodule
